FILE: hdl/ps2mct_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ps2mct_pkg
// shared types and constants of the ps/2 mouse cursor tracker
// ----------------------------------------------------------------------------
package ps2mct_pkg;

  // header byte layout
  localparam logic [7:0] SYNC_MASK  = 8'hC8;
  localparam logic [7:0] SYNC_VALUE = 8'h08;
  localparam int unsigned BTN_LEFT   = 0;
  localparam int unsigned BTN_RIGHT  = 1;
  localparam int unsigned BTN_MIDDLE = 2;
  localparam int unsigned X_SIGN     = 4;
  localparam int unsigned Y_SIGN     = 5;

  // event codes
  localparam logic [2:0] EV_MOVE   = 3'd0;
  localparam logic [2:0] EV_LEFT   = 3'd1;
  localparam logic [2:0] EV_DOUBLE = 3'd2;
  localparam logic [2:0] EV_RIGHT  = 3'd3;
  localparam logic [2:0] EV_MIDDLE = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_SCREEN_W = 3'd0;
  localparam logic [2:0] CFG_SCREEN_H = 3'd1;
  localparam logic [2:0] CFG_CURSOR_W = 3'd2;
  localparam logic [2:0] CFG_CURSOR_H = 3'd3;
  localparam logic [2:0] CFG_DCLICK   = 3'd4;

  // reset values
  localparam logic [11:0] SCREEN_W_RST = 12'd1024;
  localparam logic [11:0] SCREEN_H_RST = 12'd768;
  localparam logic [5:0]  CURSOR_W_RST = 6'd15;
  localparam logic [5:0]  CURSOR_H_RST = 6'd18;
  localparam logic [15:0] DCLICK_RST   = 16'd50;
  localparam logic [11:0] CURSOR_POS_RST = 12'd16;

  // packet completion handed to the event decoder
  typedef struct packed {
    logic        strobe;
    logic [2:0]  buttons;
    logic [31:0] tick;
  } ev_req_t;

endpackage
`default_nettype wire

FILE: hdl/ps2_mouse_cursor_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ps2_mouse_cursor_tracker
// decodes three-byte ps/2 mouse packets into cursor position and click events
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------
//  in      | sink      | in_valid / in_ready    | rx_byte, tick_now
//  out     | source    | out_valid / out_ready  | event_kind, pointer_x, pointer_y,
//          |           |                        | button_bits
//  cfg     | sink      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  one byte per cycle while in_ready is high: each request is held in the input
//  register, and the third byte of a packet moves on from there into the output
//  register; out_valid rises once that third byte is loaded into the output register
//  a waiting result stalls only a third byte behind it; header and x bytes
//  still drain, so in_ready drops only while a third byte sits in the input
//  register and the output register is full and not being read
//  synchronous reset clears phase and click tracking, sets cursor (16,16) and config
//  cfg_ready is always high; writes to unknown indexes are dropped
//
module ps2_mouse_cursor_tracker import ps2mct_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  // byte stream from the mouse
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [31:0] tick_now,
  // event stream
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       event_kind,
  output logic [11:0]      pointer_x,
  output logic [11:0]      pointer_y,
  output logic [2:0]       button_bits,
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_X      = 2'd1,
    PH_Y      = 2'd2
  } phase_t;

  // configuration
  logic [11:0] disp_width;
  logic [11:0] disp_height;
  logic [5:0]  cursor_width;
  logic [5:0]  cursor_height;
  logic [15:0] double_click_ticks;

  // input register
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic [31:0] s1_tick;

  // packet state
  phase_t      phase;
  logic [7:0]  header_byte;
  logic [7:0]  x_byte;
  logic [11:0] cursor_x;
  logic [11:0] cursor_y;

  logic              out_free;
  logic              s1_is_y;
  logic              s1_fire;
  logic              done;
  logic signed [9:0] dx;
  logic signed [9:0] dy;
  logic [11:0]       x_next;
  logic [11:0]       y_next;
  logic [2:0]        kind;
  ev_req_t           ev_req;

  assign cfg_ready = 1'b1;

  // a third byte needs the output register; other bytes always move on
  assign out_free = !out_valid || out_ready;
  assign s1_is_y  = (phase == PH_Y);
  assign s1_fire  = s1_valid && (!s1_is_y || out_free);
  assign done     = s1_fire && s1_is_y;
  assign in_ready = !s1_valid || s1_fire;

  // nine-bit deltas from header sign bits, y axis inverted
  assign dx = $signed({header_byte[X_SIGN], header_byte[X_SIGN], x_byte});
  assign dy = -$signed({header_byte[Y_SIGN], header_byte[Y_SIGN], s1_byte});

  assign ev_req.strobe  = done;
  assign ev_req.buttons = header_byte[2:0];
  assign ev_req.tick    = s1_tick;

  ps2mct_axis u_axis_x (
    .pos    (cursor_x),
    .delta  (dx),
    .screen (disp_width),
    .size   (cursor_width),
    .result (x_next)
  );

  ps2mct_axis u_axis_y (
    .pos    (cursor_y),
    .delta  (dy),
    .screen (disp_height),
    .size   (cursor_height),
    .result (y_next)
  );

  ps2mct_event u_event (
    .clk  (clk),
    .rst  (rst),
    .req  (ev_req),
    .gap  (double_click_ticks),
    .kind (kind)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      disp_width         <= SCREEN_W_RST;
      disp_height        <= SCREEN_H_RST;
      cursor_width       <= CURSOR_W_RST;
      cursor_height      <= CURSOR_H_RST;
      double_click_ticks <= DCLICK_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SCREEN_W: disp_width         <= cfg_data[11:0];
        CFG_SCREEN_H: disp_height        <= cfg_data[11:0];
        CFG_CURSOR_W: cursor_width       <= cfg_data[5:0];
        CFG_CURSOR_H: cursor_height      <= cfg_data[5:0];
        CFG_DCLICK:   double_click_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_byte <= rx_byte;
      s1_tick <= tick_now;
    end
  end

  // packet phase, cursor and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      header_byte <= 8'd0;
      x_byte      <= 8'd0;
      cursor_x    <= CURSOR_POS_RST;
      cursor_y    <= CURSOR_POS_RST;
      out_valid   <= 1'b0;
    end else begin
      if (s1_fire) begin
        case (phase)
          PH_X: begin
            x_byte <= s1_byte;
            phase  <= PH_Y;
          end
          PH_Y: begin
            phase    <= PH_HEADER;
            cursor_x <= x_next;
            cursor_y <= y_next;
          end
          default: begin
            // hunt for a header byte
            if ((s1_byte & SYNC_MASK) == SYNC_VALUE) begin
              header_byte <= s1_byte;
              phase       <= PH_X;
            end else begin
              phase <= PH_HEADER;
            end
          end
        endcase
      end
      if (done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (done) begin
      event_kind  <= kind;
      pointer_x   <= x_next;
      pointer_y   <= y_next;
      button_bits <= header_byte[2:0];
    end
  end

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    done |=> out_valid && pointer_x == cursor_x && pointer_y == cursor_y)
    else $error("completed packet did not reach the output register");

  a_cursor_hold: assert property (@(posedge clk) disable iff (rst)
    !done |=> $stable(cursor_x) && $stable(cursor_y))
    else $error("cursor moved without a completed packet");

  a_x_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pointer_x == 12'd0) ||
      ({1'b0, pointer_x} + {7'b0, cursor_width} <= {1'b0, disp_width}))
    else $error("pointer x past right edge");

  a_y_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pointer_y == 12'd0) ||
      ({1'b0, pointer_y} + {7'b0, cursor_height} <= {1'b0, disp_height}))
    else $error("pointer y past bottom edge");

endmodule
`default_nettype wire

FILE: hdl/ps2mct_axis.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ps2mct_axis
// moves one cursor coordinate by a signed delta and clamps it to the screen
// ----------------------------------------------------------------------------
module ps2mct_axis import ps2mct_pkg::*; (
  input  wire logic [11:0]       pos,
  input  wire logic signed [9:0] delta,
  input  wire logic [11:0]       screen,
  input  wire logic [5:0]        size,
  output logic [11:0]            result
);

  logic signed [13:0] p_sum;
  logic signed [13:0] p_lo;
  logic signed [13:0] reach;
  logic signed [13:0] lim;
  logic               over;

  always_comb begin
    p_sum  = $signed({2'b00, pos}) + $signed({{4{delta[9]}}, delta});
    // left / top edge
    p_lo   = p_sum[13] ? 14'sd0 : p_sum;
    reach  = p_lo + $signed({8'b0, size});
    over   = reach > $signed({2'b00, screen});
    // right / bottom edge, floored at zero
    lim    = $signed({2'b00, screen}) - $signed({8'b0, size}) - 14'sd1;
    if (over) begin
      result = lim[13] ? 12'd0 : lim[11:0];
    end else begin
      result = p_lo[11:0];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/ps2mct_event.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ps2mct_event
// button precedence and double click tracking for one completed packet
// ----------------------------------------------------------------------------
module ps2mct_event import ps2mct_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ev_req_t     req,
  input  wire logic [15:0] gap,
  output logic [2:0]       kind
);

  logic        click_pending;
  logic [31:0] first_click_tick;
  logic [31:0] elapsed;
  logic        left;

  assign left    = req.buttons[BTN_LEFT];
  assign elapsed = req.tick - first_click_tick;

  always_comb begin
    kind = EV_MOVE;
    if (left) begin
      kind = (click_pending && (elapsed < {16'b0, gap})) ? EV_DOUBLE : EV_LEFT;
    end
    if (req.buttons[BTN_RIGHT]) begin
      kind = EV_RIGHT;
    end
    if (req.buttons[BTN_MIDDLE]) begin
      kind = EV_MIDDLE;
    end
  end

  // pending flag toggles on every left-pressed packet
  always_ff @(posedge clk) begin
    if (rst) begin
      click_pending    <= 1'b0;
      first_click_tick <= 32'd0;
    end else if (req.strobe && left) begin
      click_pending <= !click_pending;
      if (!click_pending) begin
        first_click_tick <= req.tick;
      end
    end
  end

  a_pending_hold: assert property (@(posedge clk) disable iff (rst)
    !(req.strobe && left) |=> $stable(click_pending))
    else $error("click pending changed without a left packet");

  a_first_tick: assert property (@(posedge clk) disable iff (rst)
    req.strobe && left && !click_pending |=> first_click_tick == $past(req.tick))
    else $error("first click tick not captured");

endmodule
`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// regression for the ps/2 mouse cursor tracker: packet sync, signed deltas,
// edge clamping, button precedence and double clicks, checked against an
// in-bench model under random idling on the byte and event channels
// ----------------------------------------------------------------------------
module testbench;
  import ps2mct_pkg::*;

  // run bounds
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;  // input and output registers plus margin

  typedef enum logic [1:0] {
    WAIT_HDR,
    WAIT_X,
    WAIT_Y
  } pkt_phase_e;

  typedef struct {
    logic [7:0]  data;
    logic [31:0] tick;
  } mouse_byte_t;

  typedef struct {
    logic [2:0]  kind;
    logic [11:0] x;
    logic [11:0] y;
    logic [2:0]  buttons;
  } mouse_event_t;

  // dut signals, all inputs known from time zero
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = '0;
  logic [31:0] tick_now = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  event_kind;
  logic [11:0] pointer_x;
  logic [11:0] pointer_y;
  logic [2:0]  button_bits;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // model copy of the block's configuration
  logic [11:0] scr_w = SCREEN_W_RST;
  logic [11:0] scr_h = SCREEN_H_RST;
  logic [5:0]  ptr_w = CURSOR_W_RST;
  logic [5:0]  ptr_h = CURSOR_H_RST;
  logic [15:0] dbl_ticks = DCLICK_RST;

  // model copy of the block's state
  pkt_phase_e  pkt_phase = WAIT_HDR;
  logic [7:0]  hdr_lat = '0;
  logic [7:0]  x_lat = '0;
  logic        click_armed = 1'b0;
  logic [31:0] armed_tick = '0;
  logic [11:0] cur_x = CURSOR_POS_RST;
  logic [11:0] cur_y = CURSOR_POS_RST;

  // traffic bookkeeping
  mouse_byte_t  mouse_bytes[$];
  mouse_event_t pending_events[$];
  int          bytes_queued = 0;
  int          bytes_taken = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  int          send_gap = 0;
  int          stall_left = 0;
  bit          no_idle = 1'b0;
  logic [31:0] gen_tick = '0;

  ps2_mouse_cursor_tracker u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .tick_now    (tick_now),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_kind  (event_kind),
    .pointer_x   (pointer_x),
    .pointer_y   (pointer_y),
    .button_bits (button_bits),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // model of the block
  // ---------------------------------------------------------------------------

  // move one axis, then clamp low edge first and far edge second
  function automatic logic [11:0] clamp_axis(logic [11:0] pos, int delta,
                                             logic [11:0] screen, logic [5:0] size);
    int p;
    p = int'(pos) + delta;
    if (p < 0) p = 0;
    if (p + int'(size) > int'(screen)) begin
      p = int'(screen) - int'(size) - 1;
      if (p < 0) p = 0;
    end
    return 12'(p);
  endfunction

  // one accepted byte; the third byte of a packet yields one event
  task automatic decode_mouse_byte(input logic [7:0] b, input logic [31:0] tick);
    logic [2:0]   btn;
    logic [2:0]   kind;
    int           dx;
    int           dy;
    mouse_event_t ev;
    case (pkt_phase)
      WAIT_X: begin
        x_lat = b;
        pkt_phase = WAIT_Y;
      end
      WAIT_Y: begin
        pkt_phase = WAIT_HDR;
        btn = hdr_lat[2:0];
        // 9-bit deltas, sign from the header; y axis points down on screen
        dx = hdr_lat[X_SIGN] ? int'(x_lat) - 256 : int'(x_lat);
        dy = hdr_lat[Y_SIGN] ? 256 - int'(b) : -int'(b);
        kind = EV_MOVE;
        // click tracking runs even when right or middle wins the kind
        if (btn[BTN_LEFT]) begin
          kind = EV_LEFT;
          if (!click_armed) begin
            click_armed = 1'b1;
            armed_tick = tick;
          end else begin
            if (tick - armed_tick < {16'd0, dbl_ticks}) kind = EV_DOUBLE;
            click_armed = 1'b0;
          end
        end
        if (btn[BTN_RIGHT]) kind = EV_RIGHT;
        if (btn[BTN_MIDDLE]) kind = EV_MIDDLE;
        cur_x = clamp_axis(cur_x, dx, scr_w, ptr_w);
        cur_y = clamp_axis(cur_y, dy, scr_h, ptr_h);
        ev.kind = kind;
        ev.x = cur_x;
        ev.y = cur_y;
        ev.buttons = btn;
        pending_events.push_back(ev);
      end
      default: begin
        // stray bytes are dropped until a header shows up
        if ((b & SYNC_MASK) == SYNC_VALUE) begin
          hdr_lat = b;
          pkt_phase = WAIT_X;
        end else begin
          pkt_phase = WAIT_HDR;
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // idling and checks
  // ---------------------------------------------------------------------------

  // mostly back to back, sometimes a short gap, rarely a long one
  function automatic int pick_idle();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      if (mismatches < 40)
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // byte driver: one request per handshake, random gap after each
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    mouse_byte_t nxt;
    logic        holding;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      holding = in_valid;
      if (in_valid && in_ready) begin
        // request accepted at this edge, predict from the held payload
        decode_mouse_byte(rx_byte, tick_now);
        bytes_taken++;
        holding = 1'b0;
      end
      if (!holding) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (mouse_bytes.size() > 0) begin
          nxt = mouse_bytes.pop_front();
          in_valid <= 1'b1;
          rx_byte  <= nxt.data;
          tick_now <= nxt.tick;
          send_gap = pick_idle();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // event monitor: random back-pressure, in-order compare
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    mouse_event_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_events.size() == 0) begin
          if (mismatches < 40)
            $error("event with none expected: kind %0d at (%0d,%0d)",
                   event_kind, pointer_x, pointer_y);
          mismatches++;
        end else begin
          want = pending_events.pop_front();
          compare_field("event_kind", want.kind, event_kind);
          compare_field("pointer_x", want.x, pointer_x);
          compare_field("pointer_y", want.y, pointer_y);
          compare_field("button_bits", want.buttons, button_bits);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left = pick_idle();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ps2_mouse_cursor_tracker regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // config write; the model copy follows once the write is taken
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SCREEN_W: scr_w = value[11:0];
      CFG_SCREEN_H: scr_h = value[11:0];
      CFG_CURSOR_W: ptr_w = value[5:0];
      CFG_CURSOR_H: ptr_h = value[5:0];
      CFG_DCLICK:   dbl_ticks = value;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int sw, input int sh, input int cw, input int ch,
                               input int dc);
    write_reg(CFG_SCREEN_W, 16'(sw));
    write_reg(CFG_SCREEN_H, 16'(sh));
    write_reg(CFG_CURSOR_W, 16'(cw));
    write_reg(CFG_CURSOR_H, 16'(ch));
    write_reg(CFG_DCLICK, 16'(dc));
  endtask

  // sender holds off until every queued byte is taken and every event is back
  task automatic wait_idle();
    @(posedge clk);
    while (bytes_taken != bytes_queued || pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_byte(input logic [7:0] b);
    mouse_byte_t item;
    item.data = b;
    item.tick = gen_tick;
    mouse_bytes.push_back(item);
    bytes_queued++;
  endtask

  task automatic push_packet(input logic [7:0] hdr, input logic [7:0] xb,
                             input logic [7:0] yb);
    push_byte(hdr);
    push_byte(xb);
    push_byte(yb);
  endtask

  // tick steps scaled to the click window, with the odd wild jump
  task automatic advance_tick();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) ;
    else if (r < 85) gen_tick += $urandom_range(0, int'(dbl_ticks) / 4 + 1);
    else if (r < 95) gen_tick += $urandom_range(0, 2 * int'(dbl_ticks) + 2);
    else gen_tick = $urandom();
  endtask

  function automatic logic [7:0] pick_delta(input logic neg);
    if ($urandom_range(0, 1) == 0)
      return neg ? 8'($urandom_range(240, 255)) : 8'($urandom_range(0, 15));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_header();
    logic [7:0] hdr;
    hdr = SYNC_VALUE;
    hdr[5:4] = 2'($urandom_range(0, 3));
    hdr[2:0] = 3'($urandom_range(0, 7));
    // lean on plain left clicks so double clicks come up often
    if ($urandom_range(0, 3) == 0) hdr[2:0] = 3'b001;
    return hdr;
  endfunction

  // well-formed packets mostly, with stray bytes and cut-off packets mixed in
  task automatic run_traffic(input int packets);
    logic [7:0] hdr;
    int         r;
    for (int i = 0; i < packets; i++) begin
      r = $urandom_range(0, 99);
      advance_tick();
      if (r < 6) begin
        push_byte(8'($urandom_range(0, 255)));
      end else if (r < 11) begin
        push_byte(pick_header());
        if ($urandom_range(0, 1) == 0) push_byte(8'($urandom_range(0, 255)));
      end
      hdr = pick_header();
      advance_tick();
      push_byte(hdr);
      advance_tick();
      push_byte(pick_delta(hdr[X_SIGN]));
      advance_tick();
      push_byte(pick_delta(hdr[Y_SIGN]));
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int cw;
    int ch;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed, reset configuration, cursor starts at (16,16)
    gen_tick = 32'hFFFF_FFF0;
    push_byte(8'hC8);                     // top bits set, not a header
    push_byte(8'h00);                     // bit 3 clear, not a header
    push_packet(8'h08, 8'h7F, 8'h00);     // plain move right
    push_packet(8'h09, 8'h00, 8'hFF);     // left down, y pinned at top edge
    gen_tick = 32'h0000_0010;             // tick wraps, gap still inside window
    push_packet(8'h09, 8'h00, 8'h00);     // double click
    push_packet(8'h0B, 8'h01, 8'h01);     // left+right: right wins, arms click
    gen_tick = gen_tick + 32'd50;         // gap equal to window, not a double
    push_packet(8'h09, 8'h02, 8'h02);
    push_packet(8'h3D, 8'h00, 8'h00);     // middle wins, both deltas at -256
    push_packet(8'h08, 8'hFF, 8'h80);     // largest positive x step
    wait_idle();

    run_traffic(35);
    wait_idle();

    // small screen, smallest cursor, window closed
    apply_setting(64, 64, 1, 1, 0);
    run_traffic(35);
    wait_idle();

    // largest everything, no idling on either side
    no_idle = 1'b1;
    apply_setting(4095, 4095, 63, 63, 65535);
    run_traffic(35);
    wait_idle();
    no_idle = 1'b0;

    // cursor nearly as big as the screen
    apply_setting(65, 65, 63, 63, 1);
    run_traffic(35);
    wait_idle();

    // two random settings
    repeat (2) begin
      cw = $urandom_range(1, 63);
      ch = $urandom_range(1, 63);
      apply_setting($urandom_range(cw + 2, 4095), $urandom_range(ch + 2, 4095),
                    cw, ch, $urandom_range(0, 400));
      run_traffic(35);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("ps2_mouse_cursor_tracker regression: pass");
    end else begin
      $display("ps2_mouse_cursor_tracker regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/ps2mct_pkg.sv
hdl/ps2mct_axis.sv
hdl/ps2mct_event.sv
hdl/ps2_mouse_cursor_tracker.sv
verif/testbench.sv
